FILE: src/sdf_pkg.sv
package sdf_pkg;

	localparam int MAX_WORDS = 15;
	localparam int WIDX_W    = $clog2(MAX_WORDS);
	localparam int CNT_W     = 4;
	localparam int BIDX_W    = 7;

	localparam logic [7:0]  HDR0    = 8'h73;
	localparam logic [7:0]  HDR1    = 8'h6E;
	localparam logic [7:0]  HDR2    = 8'h70;
	localparam logic [15:0] HDR_SUM = 16'h0151;

	typedef logic [1:0] kind_t;
	localparam kind_t KIND_DATA = 2'd0;
	localparam kind_t KIND_ACK  = 2'd1;
	localparam kind_t KIND_ERR  = 2'd2;

	typedef struct packed {
		logic              init_sum;
		logic              acc;
		logic              ld_type;
		logic              ld_addr;
		logic              shift;
		logic              store;
		logic [WIDX_W-1:0] widx;
		logic              ld_rsum_hi;
		logic              ld_rsum_lo;
		logic              emit;
		kind_t             kind;
		logic [WIDX_W-1:0] ridx;
		logic              last;
	} sdf_cmd_t;

	typedef struct packed {
		logic             is_h0;
		logic             is_h1;
		logic             is_h2;
		logic             data_present;
		logic [CNT_W-1:0] word_cnt;
		logic             sum_ok;
		logic             out_free;
	} sdf_stat_t;

endpackage

FILE: src/sdf_in_if.sv
interface sdf_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

FILE: src/sdf_out_if.sv
interface sdf_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [8:0]  word_address;
	logic [31:0] word_value;
	logic        failed_flag;
	logic        last;

	modport source (output valid, output kind, output word_address, output word_value,
		output failed_flag, output last, input ready);
	modport sink (input valid, input kind, input word_address, input word_value,
		input failed_flag, input last, output ready);
endinterface

FILE: src/sdf_datapath.sv
module sdf_datapath
	import sdf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic [7:0]  rx_byte,
	input  sdf_cmd_t    cmd,
	output sdf_stat_t   stat,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic [8:0]  word_address,
	output logic [31:0] word_value,
	output logic        failed_flag,
	output logic        last
);

	logic [7:0]  type_q;
	logic [7:0]  base_q;
	logic [15:0] sum_q;
	logic [15:0] rsum_q;
	logic [31:0] asm_q;
	logic [31:0] store_q [MAX_WORDS];
	logic [31:0] asm_next;
	logic        out_valid_q;
	kind_t       kind_q;
	logic [8:0]  addr_q;
	logic [31:0] value_q;
	logic        failed_q;
	logic        last_q;

	assign asm_next = {asm_q[23:0], rx_byte};

	always_comb begin
		stat.is_h0        = (rx_byte == HDR0);
		stat.is_h1        = (rx_byte == HDR1);
		stat.is_h2        = (rx_byte == HDR2);
		stat.data_present = type_q[7];
		stat.word_cnt     = (type_q[7] && !type_q[6]) ? CNT_W'(1) : type_q[5:2];
		stat.sum_ok       = (sum_q == rsum_q);
		stat.out_free     = !out_valid_q || out_ready;
	end

	always_ff @(posedge clk) begin
		if (cmd.init_sum) begin
			sum_q <= HDR_SUM;
		end else if (cmd.acc) begin
			sum_q <= sum_q + {8'd0, rx_byte};
		end
		if (cmd.ld_type) begin
			type_q <= rx_byte;
		end
		if (cmd.ld_addr) begin
			base_q <= rx_byte;
			asm_q  <= '0;
		end else if (cmd.shift) begin
			asm_q <= asm_next;
		end
		if (cmd.store) begin
			store_q[cmd.widx] <= asm_next;
		end
		if (cmd.ld_rsum_hi) begin
			rsum_q <= {rx_byte, 8'd0};
		end else if (cmd.ld_rsum_lo) begin
			rsum_q <= {rsum_q[15:8], rx_byte};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			kind_q <= cmd.kind;
			last_q <= cmd.last;
			case (cmd.kind)
				KIND_DATA: begin
					addr_q   <= {1'b0, base_q} + {{(9 - WIDX_W){1'b0}}, cmd.ridx};
					value_q  <= store_q[cmd.ridx];
					failed_q <= type_q[0];
				end
				KIND_ACK: begin
					addr_q   <= {1'b0, base_q};
					value_q  <= '0;
					failed_q <= type_q[0];
				end
				default: begin
					addr_q   <= '0;
					value_q  <= '0;
					failed_q <= 1'b0;
				end
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign kind         = kind_q;
	assign word_address = addr_q;
	assign word_value   = value_q;
	assign failed_flag  = failed_q;
	assign last         = last_q;

endmodule

FILE: src/sdf_ctrl.sv
module sdf_ctrl
	import sdf_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  sdf_stat_t stat,
	output sdf_cmd_t  cmd
);

	typedef enum logic [1:0] {
		ST_HUNT,
		ST_BODY,
		ST_EMIT
	} state_t;

	state_t             state_q;
	logic [1:0]         hm_q;
	logic [BIDX_W-1:0]  bidx_q;
	logic [WIDX_W-1:0]  didx_q;
	logic               take;
	logic [BIDX_W-1:0]  d;
	logic [BIDX_W-1:0]  nbytes;
	logic [CNT_W-1:0]   emit_n;
	logic [WIDX_W-1:0]  wsel;
	logic               in_words;
	logic               at_hi;

	assign in_ready = (state_q != ST_EMIT);
	assign take     = in_valid && in_ready;
	assign d        = bidx_q - BIDX_W'(3);
	assign nbytes   = {{(BIDX_W - CNT_W - 2){1'b0}}, stat.word_cnt, 2'b00};
	assign in_words = (bidx_q >= BIDX_W'(3)) && (d < nbytes);
	assign at_hi    = (bidx_q >= BIDX_W'(3)) && (d == nbytes);
	assign wsel     = WIDX_W'(d >> 2);
	assign emit_n   = (32'(stat.word_cnt) > MAX_WORDS) ? CNT_W'(MAX_WORDS) : stat.word_cnt;

	always_comb begin
		cmd = '0;
		cmd.widx = wsel;
		cmd.ridx = didx_q;
		case (state_q)
			ST_HUNT: begin
				cmd.init_sum = take && (hm_q == 2'd2) && stat.is_h2;
			end
			ST_BODY: begin
				if (take) begin
					if (bidx_q == BIDX_W'(1)) begin
						cmd.ld_type = 1'b1;
						cmd.acc     = 1'b1;
					end else if (bidx_q == BIDX_W'(2)) begin
						cmd.ld_addr = 1'b1;
						cmd.acc     = 1'b1;
					end else if (in_words) begin
						cmd.acc   = 1'b1;
						cmd.shift = 1'b1;
						cmd.store = (d[1:0] == 2'd3) && (32'(d >> 2) < MAX_WORDS);
					end else if (at_hi) begin
						cmd.ld_rsum_hi = 1'b1;
					end else begin
						cmd.ld_rsum_lo = 1'b1;
					end
				end
			end
			ST_EMIT: begin
				if (stat.out_free) begin
					if (!stat.sum_ok) begin
						cmd.emit = 1'b1;
						cmd.kind = KIND_ERR;
						cmd.last = 1'b1;
					end else if (!stat.data_present) begin
						cmd.emit = 1'b1;
						cmd.kind = KIND_ACK;
						cmd.last = 1'b1;
					end else if (emit_n != '0) begin
						cmd.emit = 1'b1;
						cmd.kind = KIND_DATA;
						cmd.last = ({1'b0, didx_q} + 5'd1) == {1'b0, emit_n};
					end
				end
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_HUNT;
			hm_q    <= '0;
			bidx_q  <= '0;
			didx_q  <= '0;
		end else begin
			case (state_q)
				ST_HUNT: begin
					if (take) begin
						if (hm_q == 2'd2 && stat.is_h2) begin
							hm_q    <= '0;
							bidx_q  <= BIDX_W'(1);
							state_q <= ST_BODY;
						end else if (hm_q == 2'd1 && stat.is_h1) begin
							hm_q <= 2'd2;
						end else begin
							hm_q <= {1'b0, stat.is_h0};
						end
					end
				end
				ST_BODY: begin
					if (take) begin
						if (cmd.ld_rsum_lo) begin
							bidx_q  <= '0;
							didx_q  <= '0;
							state_q <= ST_EMIT;
						end else begin
							bidx_q <= bidx_q + BIDX_W'(1);
						end
					end
				end
				ST_EMIT: begin
					if (stat.out_free) begin
						if (!cmd.emit || cmd.last) begin
							state_q <= ST_HUNT;
						end else begin
							didx_q <= didx_q + WIDX_W'(1);
						end
					end
				end
				default: begin
					state_q <= ST_HUNT;
				end
			endcase
		end
	end

endmodule

FILE: src/sensor_packet_deframer_sum16_top.sv
// channel  dir  payload                                          handshake
// rx       in   rx_byte[7:0]                                     valid/ready
// res      out  kind[1:0] word_address[8:0] word_value[31:0]     valid/ready
//               failed_flag last
// one byte per cycle while hunting and framing; rx.ready is low from the cycle after
// the last checksum byte until the final result of that packet is loaded
// results leave one per cycle from the output register while res.ready is high, up to 15 per packet
// a packet with no result holds rx.ready low one cycle, longer while res is full
// a stalled res side holds the output register, and rx.ready with it only while
// a packet drains; arst_n clears the controller and the output valid, no clearing pass
module sensor_packet_deframer_sum16_top
	import sdf_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	sdf_in_if.sink    rx,
	sdf_out_if.source res
);

	sdf_cmd_t  cmd;
	sdf_stat_t stat;

	sdf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (rx.valid),
		.in_ready (rx.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	sdf_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.rx_byte      (rx.rx_byte),
		.cmd          (cmd),
		.stat         (stat),
		.out_valid    (res.valid),
		.out_ready    (res.ready),
		.kind         (res.kind),
		.word_address (res.word_address),
		.word_value   (res.word_value),
		.failed_flag  (res.failed_flag),
		.last         (res.last)
	);

endmodule
